FILE: design/vesc_pkg.sv
// vesc_pkg: shared types and codes for the varint entry stream checker.
`default_nettype none

package vesc_pkg;

    localparam logic [1:0] PH_FREQ = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_LEX  = 2'd2;

    localparam logic [2:0] K_CONT  = 3'd0;
    localparam logic [2:0] K_FREQ  = 3'd1;
    localparam logic [2:0] K_LEN   = 3'd2;
    localparam logic [2:0] K_LEX   = 3'd3;
    localparam logic [2:0] K_TRAIL = 3'd4;
    localparam logic [2:0] K_IGN   = 3'd5;

    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_OK      = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_OVER32  = 3'd3;
    localparam logic [2:0] ST_TRUNC   = 3'd4;
    localparam logic [2:0] ST_OVERRUN = 3'd5;

    localparam logic [2:0] MAX_CONT = 3'd4;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        start_of_buffer;
        logic        end_of_buffer;
        logic [30:0] expected_entries;
    } vesc_req_t;

    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [31:0] decoded_value;
        logic [30:0] entry_number;
        logic [2:0]  status;
        logic        finished;
    } vesc_res_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic [31:0] acc;
        logic [2:0]  cont_cnt;
        logic [31:0] lex_left;
        logic [30:0] done;
        logic [30:0] expected;
        logic [2:0]  status;
    } vesc_state_t;

endpackage

`default_nettype wire

FILE: design/vesc_if.sv
// vesc_if: request and result channel interfaces.
`default_nettype none

interface vesc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        start_of_buffer;
    logic        end_of_buffer;
    logic [30:0] expected_entries;

    modport source (output valid, output data_byte, output byte_valid,
                    output start_of_buffer, output end_of_buffer,
                    output expected_entries, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input start_of_buffer, input end_of_buffer,
                    input expected_entries, output ready);
endinterface

interface vesc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_kind;
    logic [31:0] decoded_value;
    logic [30:0] entry_number;
    logic [2:0]  status;
    logic        finished;

    modport source (output valid, output byte_kind, output decoded_value,
                    output entry_number, output status, output finished,
                    input ready);
    modport sink   (input valid, input byte_kind, input decoded_value,
                    input entry_number, input status, input finished,
                    output ready);
endinterface

`default_nettype wire

FILE: design/vesc_step.sv
// vesc_step: per-byte classification and next-state logic.
`default_nettype none

module vesc_step
    import vesc_pkg::*;
(
    input  vesc_state_t state_cur,
    input  vesc_req_t   req,
    output vesc_state_t state_nxt,
    output vesc_res_t   res
);

    vesc_state_t cur;
    vesc_state_t nxt;
    logic [31:0] shifted;
    logic [31:0] acc_new;
    logic [31:0] b_low;
    logic [2:0]  kind;
    logic [31:0] val;

    assign b_low = {25'd0, req.data_byte[6:0]};

    always_comb
    begin
        unique case (cur.cont_cnt)
            3'd0:    shifted = b_low;
            3'd1:    shifted = b_low << 7;
            3'd2:    shifted = b_low << 14;
            3'd3:    shifted = b_low << 21;
            3'd4:    shifted = b_low << 28;
            default: shifted = '0;
        endcase
    end

    assign acc_new = cur.acc | shifted;

    always_comb
    begin
        if (req.start_of_buffer)
        begin
            cur          = '0;
            cur.phase    = PH_FREQ;
            cur.status   = ST_RUN;
            cur.expected = req.expected_entries;
        end
        else
        begin
            cur = state_cur;
        end

        nxt  = cur;
        kind = K_IGN;
        val  = '0;

        if (cur.status == ST_RUN)
        begin
            if (req.byte_valid)
            begin
                if (cur.done >= cur.expected)
                begin
                    kind = K_TRAIL;
                end
                else if (cur.phase == PH_LEX)
                begin
                    kind         = K_LEX;
                    val          = {24'd0, req.data_byte};
                    nxt.lex_left = cur.lex_left - 32'd1;
                    if (nxt.lex_left == '0)
                    begin
                        nxt.done  = cur.done + 31'd1;
                        nxt.phase = PH_FREQ;
                    end
                end
                else if (req.data_byte[7] && (cur.cont_cnt >= MAX_CONT))
                begin
                    kind       = K_CONT;
                    nxt.status = ST_OVER32;
                end
                else if (req.data_byte[7])
                begin
                    kind         = K_CONT;
                    nxt.acc      = acc_new;
                    nxt.cont_cnt = cur.cont_cnt + 3'd1;
                end
                else
                begin
                    val          = acc_new;
                    nxt.acc      = '0;
                    nxt.cont_cnt = '0;
                    if (cur.phase == PH_FREQ)
                    begin
                        kind      = K_FREQ;
                        nxt.phase = PH_LEN;
                    end
                    else
                    begin
                        kind         = K_LEN;
                        nxt.lex_left = acc_new;
                        if (acc_new == '0)
                        begin
                            nxt.done  = cur.done + 31'd1;
                            nxt.phase = PH_FREQ;
                        end
                        else
                        begin
                            nxt.phase = PH_LEX;
                        end
                    end
                end
            end

            if (req.end_of_buffer && (nxt.status == ST_RUN))
            begin
                priority if (nxt.done >= nxt.expected)
                    nxt.status = ST_OK;
                else if (nxt.phase == PH_LEX)
                    nxt.status = ST_OVERRUN;
                else if ((nxt.phase == PH_LEN) || (nxt.cont_cnt != '0))
                    nxt.status = ST_TRUNC;
                else
                    nxt.status = ST_MISSING;
            end
        end
    end

    assign state_nxt         = nxt;
    assign res.byte_kind     = kind;
    assign res.decoded_value = val;
    assign res.entry_number  = cur.done;
    assign res.status        = nxt.status;
    assign res.finished      = (nxt.status != ST_RUN);

endmodule

`default_nettype wire

FILE: design/varint_entry_stream_checker.sv
// Path: input register holds the accepted request, then the result register takes its result.
// One request per cycle unless results stall; per-byte state update sits between the registers.
// The input register holds while the result register is stalled; ready drops only then.
// Reset: rst_n clears the parse state (frequency phase, counts zero, status running)
// and both valid flags; no clearing pass.
`default_nettype none

module varint_entry_stream_checker
    import vesc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    vesc_in_if.sink   bytes,
    vesc_out_if.source results
);

    logic        in_valid_reg;
    logic        in_valid_next;
    vesc_req_t   in_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    vesc_res_t   out_data_reg;
    vesc_state_t state_reg;
    vesc_state_t state_next;
    vesc_res_t   step_res;
    logic        advance;
    logic        accept_in;

    assign advance   = in_valid_reg && (!out_valid_reg || results.ready);
    assign bytes.ready = !in_valid_reg || advance;
    assign accept_in = bytes.valid && bytes.ready;

    vesc_step u_step (
        .state_cur (state_reg),
        .req       (in_data_reg),
        .state_nxt (state_next),
        .res       (step_res)
    );

    always_comb
    begin
        if (accept_in)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // all-zero state is frequency phase, status running
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            in_data_reg.data_byte        <= bytes.data_byte;
            in_data_reg.byte_valid       <= bytes.byte_valid;
            in_data_reg.start_of_buffer  <= bytes.start_of_buffer;
            in_data_reg.end_of_buffer    <= bytes.end_of_buffer;
            in_data_reg.expected_entries <= bytes.expected_entries;
        end
        if (advance)
            out_data_reg <= step_res;
    end

    assign results.valid         = out_valid_reg;
    assign results.byte_kind     = out_data_reg.byte_kind;
    assign results.decoded_value = out_data_reg.decoded_value;
    assign results.entry_number  = out_data_reg.entry_number;
    assign results.status        = out_data_reg.status;
    assign results.finished      = out_data_reg.finished;

    // continuation count never passes the fifth-byte limit
    a_cont_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cont_cnt <= MAX_CONT)
        else $error("continuation count out of range");

    // lexeme phase always has bytes still due
    a_lex_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_LEX) |-> (state_reg.lex_left != '0))
        else $error("lexeme phase with nothing left");

    // a latched status holds until a new buffer starts
    a_latch_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (state_reg.status != ST_RUN) && !in_data_reg.start_of_buffer)
        |=> (state_reg == $past(state_reg)))
        else $error("latched state changed");

    // a request taken with a stalled result must not be lost
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("pending request dropped");

endmodule

`default_nettype wire
